// ===== design/tbfu_pkg.sv =====
// ----------------------------------------------------------------------------
// Tensor byte unpacker package
// Shared payload types, element type codes and the half-to-single widening
// function used by the conversion stage.
// ----------------------------------------------------------------------------
package tbfu_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned ETYPE_W = 2;

    // Element type codes held in the configuration register.
    localparam logic [ETYPE_W-1:0] ET_SINGLE = 2'd0;
    localparam logic [ETYPE_W-1:0] ET_HALF   = 2'd1;
    localparam logic [ETYPE_W-1:0] ET_BF16   = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] single_bits;
        logic              last_value;
        logic              short_tail;
    } t_out_item;

    // Gathered element on its way from the gather stage to the conversion stage.
    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [ETYPE_W-1:0] elem_type;
        logic               last_value;
        logic               short_tail;
    } t_word_item;

    // Exact widening of an IEEE half-precision pattern to single precision.
    function automatic logic [WORD_W-1:0] widen_half(input logic [15:0] h);
        logic       sign;
        logic [4:0] expo;
        logic [9:0] mant;
        logic [3:0] msb;
        logic [3:0] shift;
        logic [10:0] shifted;
        logic [7:0] sub_exp;
        logic [WORD_W-1:0] res;
        sign    = h[15];
        expo    = h[14:10];
        mant    = h[9:0];
        msb     = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (mant[i]) begin
                msb = 4'(i);
            end
        end
        // Subnormal: shift the leading one up to the hidden-bit position.
        shift   = 4'd10 - msb;
        shifted = {1'b0, mant} << shift;
        sub_exp = 8'd113 - {4'd0, shift};
        if (expo == 5'd0) begin
            if (mant == 10'd0) begin
                res = {sign, 31'd0};
            end else begin
                res = {sign, sub_exp, shifted[9:0], 13'd0};
            end
        end else if (expo == 5'h1f) begin
            res = {sign, 8'hff, mant, 13'd0};
        end else begin
            res = {sign, 8'({3'd0, expo} + 8'd112), mant, 13'd0};
        end
        return res;
    endfunction

endpackage

// ===== design/tbfu_gather.sv =====
// ----------------------------------------------------------------------------
// Tensor byte unpacker: gather stage
// Holds the element type register and assembles little-endian bytes into
// elements; a completed element or a short tail is registered for conversion.
// ----------------------------------------------------------------------------
module tbfu_gather (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  tbfu_pkg::t_in_item             i_in,
    input  logic                           i_cfg_valid,
    input  logic [tbfu_pkg::ETYPE_W-1:0]   i_cfg_data,
    output logic                           o_item_valid,
    input  logic                           i_item_ready,
    output tbfu_pkg::t_word_item           o_item
);

    logic [tbfu_pkg::ETYPE_W-1:0] r_elem_type;
    logic [23:0]                  r_gathered, n_gathered;
    logic [1:0]                   r_pos, n_pos;
    logic                         r_valid, n_valid;
    tbfu_pkg::t_word_item         r_item, n_item;

    logic        accept;
    logic        two_byte;
    logic        complete;
    logic [31:0] word;

    assign o_in_ready = !r_valid || i_item_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign two_byte   = (r_elem_type == tbfu_pkg::ET_HALF) ||
                        (r_elem_type == tbfu_pkg::ET_BF16);
    assign complete   = two_byte ? (r_pos != 2'd0) : (r_pos == 2'd3);
    assign word       = {8'd0, r_gathered} | ({24'd0, i_in.data_byte} << {r_pos, 3'd0});

    always_comb begin
        n_gathered = r_gathered;
        n_pos      = r_pos;
        n_valid    = r_valid && !i_item_ready;
        n_item     = r_item;
        if (accept) begin
            if (complete) begin
                n_valid           = 1'b1;
                n_item.word       = word;
                n_item.elem_type  = r_elem_type;
                n_item.last_value = i_in.last_byte;
                n_item.short_tail = 1'b0;
                n_gathered        = 24'd0;
                n_pos             = 2'd0;
            end else if (i_in.last_byte) begin
                n_valid           = 1'b1;
                n_item.word       = '0;
                n_item.elem_type  = tbfu_pkg::ET_SINGLE;
                n_item.last_value = 1'b1;
                n_item.short_tail = 1'b1;
                n_gathered        = 24'd0;
                n_pos             = 2'd0;
            end else begin
                n_gathered = word[23:0];
                n_pos      = r_pos + 2'd1;
            end
        end
        // A type change discards any partial element.
        if (i_cfg_valid) begin
            n_gathered = 24'd0;
            n_pos      = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_type <= tbfu_pkg::ET_SINGLE;
            r_gathered  <= 24'd0;
            r_pos       <= 2'd0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_elem_type <= i_cfg_data;
            end
            r_gathered <= n_gathered;
            r_pos      <= n_pos;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

// ===== design/tbfu_convert.sv =====
// ----------------------------------------------------------------------------
// Tensor byte unpacker: conversion stage
// Turns a gathered element into a single-precision pattern and holds it in
// the result register until the downstream transfer.
// ----------------------------------------------------------------------------
module tbfu_convert (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    output logic                  o_item_ready,
    input  tbfu_pkg::t_word_item  i_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tbfu_pkg::t_out_item   o_out
);

    logic                r_valid;
    tbfu_pkg::t_out_item r_out, n_out;
    logic                load;

    assign o_item_ready = !r_valid || i_out_ready;
    assign load         = i_item_valid && o_item_ready;

    always_comb begin
        n_out.last_value = i_item.last_value;
        n_out.short_tail = i_item.short_tail;
        case (i_item.elem_type)
            tbfu_pkg::ET_HALF: n_out.single_bits = tbfu_pkg::widen_half(i_item.word[15:0]);
            tbfu_pkg::ET_BF16: n_out.single_bits = {i_item.word[15:0], 16'd0};
            default:           n_out.single_bits = i_item.word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_item_ready) begin
            r_valid <= i_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

endmodule

// ===== design/tensor_byte_to_fp32_unpacker.sv =====
// ----------------------------------------------------------------------------
// Tensor byte to single-precision unpacker
// Gathers little-endian bytes into 4-byte or 2-byte elements and emits one
// single-precision word per element, or a short-tail flag on a cut element.
// ----------------------------------------------------------------------------
// Path: its final byte passes the gather register, then the result register.
// Throughput: one byte per cycle; the gather and conversion registers form a
// two-stage pipeline that stalls only when the result register is not taken.
// Reset: synchronous, active low; the element type returns to single
// precision and any partial element and pending result are discarded.
module tensor_byte_to_fp32_unpacker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tbfu_pkg::t_in_item            i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tbfu_pkg::t_out_item           o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tbfu_pkg::ETYPE_W-1:0]  i_cfg_data
);

    logic                 item_valid;
    logic                 item_ready;
    tbfu_pkg::t_word_item item;

    assign o_cfg_ready = 1'b1;

    tbfu_gather u_gather (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_item_valid (item_valid),
        .i_item_ready (item_ready),
        .o_item       (item)
    );

    tbfu_convert u_convert (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .o_item_ready (item_ready),
        .i_item       (item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out)
    );

endmodule

// ===== design/tbfu_checker.sv =====
// ----------------------------------------------------------------------------
// Tensor byte unpacker checker
// Port-level assertions on the unpacker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tbfu_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_ready,
    input  tbfu_pkg::t_in_item            i_in,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  tbfu_pkg::t_out_item           o_out,
    input  logic                          i_cfg_valid,
    input  logic                          o_cfg_ready,
    input  logic [tbfu_pkg::ETYPE_W-1:0]  i_cfg_data
);

    // A stalled result holds its value until the transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // A cut element always ends the tensor and carries a zero value.
    a_short_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.short_tail |-> o_out.last_value && (o_out.single_bits == 32'd0))
        else $error("short tail result malformed");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A result rises from an empty output only after a byte passes the gather register.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && i_rst_n, 2))
        else $error("result without a preceding byte transfer");

endmodule

bind tensor_byte_to_fp32_unpacker tbfu_checker u_checker (.*);
